/* src/ral_pkg.sv */
// Shared definitions for the resource archive locator: parse phases, verdict codes,
// the archive signature, lead-byte classes and the parse state and result structs.
// No dependencies; every other file in src imports this package.
package ral_pkg;

    localparam int POSITION_BITS_DEFAULT = 24;

    // Configuration port layout.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_TYPE     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_RESOURCE = 2'd1;

    // Result field widths, fixed by the interface.
    localparam int OFFSET_BITS = 24;
    localparam int LENGTH_BITS = 23;

    typedef enum logic [9:0] {
        PH_SIG0    = 10'b00_0000_0001,
        PH_SIG1    = 10'b00_0000_0010,
        PH_SIG2    = 10'b00_0000_0100,
        PH_SIG3    = 10'b00_0000_1000,
        PH_LEAD    = 10'b00_0001_0000,
        PH_RID_LO  = 10'b00_0010_0000,
        PH_RES_MID = 10'b00_0100_0000,
        PH_RES_LO  = 10'b00_1000_0000,
        PH_PAYLOAD = 10'b01_0000_0000,
        PH_DONE    = 10'b10_0000_0000
    } phase_t;

    typedef enum logic [1:0] {
        V_FOUND  = 2'd0,
        V_ABSENT = 2'd1,
        V_BAD    = 2'd2
    } verdict_t;

    localparam logic [7:0] SIGNATURE [4] = '{8'h00, 8'h45, 8'h52, 8'h4D};

    // Lead byte classes, taken from the top two bits of the lead.
    localparam logic [1:0] LEAD_TYPE     = 2'b00;
    localparam logic [1:0] LEAD_DELTA    = 2'b01;
    localparam logic [1:0] LEAD_PAYLOAD  = 2'b10;
    localparam logic [1:0] LEAD_RESERVED = 2'b11;

    localparam logic [16:0] RESOURCE_MAX = 17'h0FFFF;

    typedef struct packed {
        phase_t      phase;
        logic [8:0]  type_id;
        logic [16:0] resource_id;
        logic [21:0] length_partial;
        logic [22:0] payload_remaining;
        logic        match_pending;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        phase:             PH_SIG0,
        type_id:           9'd1,
        resource_id:       17'd1,
        length_partial:    22'd0,
        payload_remaining: 23'd0,
        match_pending:     1'b0
    };

    typedef struct packed {
        logic                   valid;
        verdict_t               verdict;
        logic [OFFSET_BITS-1:0] offset;
        logic [LENGTH_BITS-1:0] length;
    } result_t;

endpackage

/* src/ral_step.sv */
// One parse step of the resource archive locator: next parse state, next byte position
// and the optional verdict for a single archive byte. Purely combinational.
// Depends on ral_pkg.
module ral_step #(
    parameter int POSITION_BITS = ral_pkg::POSITION_BITS_DEFAULT
) (
    input  ral_pkg::parse_state_t     cur,
    input  logic [POSITION_BITS-1:0]  pos,
    input  logic [7:0]                data_byte,
    input  logic                      end_of_archive,
    input  logic [7:0]                target_type,
    input  logic [15:0]               target_resource,
    output ral_pkg::parse_state_t     nxt,
    output logic [POSITION_BITS-1:0]  pos_next,
    output ral_pkg::result_t          res
);
    import ral_pkg::*;

    localparam int OFF_EXT_W = (POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS;

    logic [8:0]               type_sum;
    logic [16:0]              rid_sum;
    logic [22:0]              rem_dec;
    logic [22:0]              len_found;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] off_full;
    logic [OFF_EXT_W-1:0]     off_ext;
    logic                     have;
    logic                     found;
    verdict_t                 verdict;

    assign type_sum  = 9'(cur.type_id + 9'(data_byte));
    assign rid_sum   = 17'(cur.resource_id + 17'({cur.length_partial[5:0], data_byte}) + 17'd1);
    assign rem_dec   = cur.payload_remaining - 23'd1;
    assign len_found = 23'(cur.length_partial) + 23'd1;
    assign pos_inc   = pos + POSITION_BITS'(1);
    assign off_full  = pos_inc - POSITION_BITS'(len_found);
    assign off_ext   = OFF_EXT_W'(off_full);

    always_comb
    begin
        nxt     = cur;
        have    = 1'b0;
        found   = 1'b0;
        verdict = V_ABSENT;
        unique case (cur.phase)
            PH_SIG0, PH_SIG1, PH_SIG2:
            begin
                if (data_byte != SIGNATURE[cur.phase == PH_SIG0 ? 0 :
                                           (cur.phase == PH_SIG1 ? 1 : 2)])
                begin
                    have    = 1'b1;
                    verdict = V_BAD;
                end
                else
                begin
                    nxt.phase = (cur.phase == PH_SIG0) ? PH_SIG1 :
                                ((cur.phase == PH_SIG1) ? PH_SIG2 : PH_SIG3);
                    if (end_of_archive)
                    begin
                        have    = 1'b1;
                        verdict = V_BAD;
                    end
                end
            end
            PH_SIG3:
            begin
                if (data_byte != SIGNATURE[3])
                begin
                    have    = 1'b1;
                    verdict = V_BAD;
                end
                else
                begin
                    nxt.phase = PH_LEAD;
                    if (end_of_archive)
                    begin
                        have    = 1'b1;
                        verdict = V_ABSENT;
                    end
                end
            end
            PH_LEAD:
            begin
                if (data_byte == 8'h00)
                begin
                    have    = 1'b1;
                    verdict = V_ABSENT;
                end
                else
                begin
                    case (data_byte[7:6])
                        LEAD_TYPE:
                        begin
                            nxt.type_id     = type_sum;
                            nxt.resource_id = 17'd1;
                            if (type_sum > {1'b0, target_type})
                            begin
                                have    = 1'b1;
                                verdict = V_BAD;
                            end
                            else if (end_of_archive)
                            begin
                                have    = 1'b1;
                                verdict = V_ABSENT;
                            end
                        end
                        LEAD_DELTA:
                        begin
                            nxt.length_partial = {16'd0, data_byte[5:0]};
                            nxt.phase          = PH_RID_LO;
                            if (end_of_archive)
                            begin
                                have    = 1'b1;
                                verdict = V_BAD;
                            end
                        end
                        LEAD_PAYLOAD:
                        begin
                            nxt.length_partial = {16'd0, data_byte[5:0]};
                            nxt.phase          = PH_RES_MID;
                            if (end_of_archive)
                            begin
                                have    = 1'b1;
                                verdict = V_BAD;
                            end
                        end
                        default:
                        begin
                            // Reserved lead class.
                            have    = 1'b1;
                            verdict = V_BAD;
                        end
                    endcase
                end
            end
            PH_RID_LO:
            begin
                nxt.resource_id = rid_sum;
                nxt.phase       = PH_LEAD;
                if (rid_sum > RESOURCE_MAX)
                begin
                    have    = 1'b1;
                    verdict = V_BAD;
                end
                else if (end_of_archive)
                begin
                    have    = 1'b1;
                    verdict = V_ABSENT;
                end
            end
            PH_RES_MID:
            begin
                nxt.length_partial = {8'd0, cur.length_partial[5:0], data_byte};
                nxt.phase          = PH_RES_LO;
                if (end_of_archive)
                begin
                    have    = 1'b1;
                    verdict = V_BAD;
                end
            end
            PH_RES_LO:
            begin
                nxt.length_partial    = {cur.length_partial[13:0], data_byte};
                nxt.payload_remaining = 23'({cur.length_partial[13:0], data_byte}) + 23'd1;
                nxt.match_pending     = (cur.type_id == {1'b0, target_type}) &&
                                        (cur.resource_id == {1'b0, target_resource});
                nxt.phase             = PH_PAYLOAD;
                if (end_of_archive)
                begin
                    have    = 1'b1;
                    verdict = V_BAD;
                end
            end
            PH_PAYLOAD:
            begin
                nxt.payload_remaining = rem_dec;
                if (rem_dec == 23'd0)
                begin
                    if (cur.match_pending)
                    begin
                        have    = 1'b1;
                        found   = 1'b1;
                        verdict = V_FOUND;
                    end
                    else
                    begin
                        nxt.phase = PH_LEAD;
                        if (end_of_archive)
                        begin
                            have    = 1'b1;
                            verdict = V_ABSENT;
                        end
                    end
                end
                else if (end_of_archive)
                begin
                    have    = 1'b1;
                    verdict = V_BAD;
                end
            end
            default:
            begin
                // A verdict was already given: bytes pass until the archive ends.
            end
        endcase

        if (have)
        begin
            nxt.phase = PH_DONE;
        end
        if (end_of_archive)
        begin
            nxt = PARSE_RESET;
        end
    end

    assign pos_next    = end_of_archive ? '0 : pos_inc;
    assign res.valid   = have;
    assign res.verdict = verdict;
    assign res.offset  = found ? off_ext[OFFSET_BITS-1:0] : '0;
    assign res.length  = found ? len_found : '0;

endmodule

/* src/resource_archive_locator_unit.sv */
// Top level of the resource archive locator: parse state, configuration registers,
// byte position counter, result register and checks.
// Depends on ral_pkg and ral_step.

// The locator takes one archive byte per beat and gives at most one verdict beat
// per archive: found (with payload offset and length), absent, or malformed. Each
// byte is parsed by a single pass of small adders and comparators on the registered
// parse state, so a byte is accepted in every cycle but for the stall below, and a
// verdict appears on the result port in the cycle after the byte that decides it. The
// only thing that holds the input back is a verdict that sits in the result register
// while the result side stalls; bytes that give no verdict never wait on the result
// side otherwise. The user must write target_type and target_resource through the
// configuration port only while no archive is in flight (the block does not enforce
// this); they are kept across archives; an end_of_archive byte resets all parse state.
module resource_archive_locator_unit #(
    parameter int POSITION_BITS = ral_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_write,
    input  logic [ral_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ral_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // Archive byte channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          data_byte,
    input  logic                                end_of_archive,
    // Verdict channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          verdict,
    output logic [ral_pkg::OFFSET_BITS-1:0]     payload_offset,
    output logic [ral_pkg::LENGTH_BITS-1:0]     payload_length
);
    import ral_pkg::*;

    parse_state_t             state_reg;
    parse_state_t             state_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [7:0]               target_type_reg;
    logic [15:0]              target_resource_reg;
    result_t                  step_res;
    logic                     out_valid_reg;
    verdict_t                 verdict_reg;
    logic [OFFSET_BITS-1:0]   offset_reg;
    logic [LENGTH_BITS-1:0]   length_reg;
    logic                     in_beat;
    logic                     out_beat;
    logic                     load_result;

    // The input waits only while a verdict is held by a stalled result side.
    assign in_stall    = out_valid_reg && out_stall;
    assign in_beat     = in_valid && !in_stall;
    assign out_beat    = out_valid_reg && !out_stall;
    assign load_result = in_beat && step_res.valid;

    ral_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .cur             (state_reg),
        .pos             (pos_reg),
        .data_byte       (data_byte),
        .end_of_archive  (end_of_archive),
        .target_type     (target_type_reg),
        .target_resource (target_resource_reg),
        .nxt             (state_next),
        .pos_next        (pos_next),
        .res             (step_res)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_type_reg     <= 8'd1;
            target_resource_reg <= 16'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TARGET_TYPE:     target_type_reg     <= cfg_data[7:0];
                CFG_TARGET_RESOURCE: target_resource_reg <= cfg_data;
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // Parse state and byte position advance on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PARSE_RESET;
            pos_reg   <= '0;
        end
        else if (in_beat)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // Result register: filled by a deciding byte, emptied when the beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_beat)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            verdict_reg <= step_res.verdict;
            offset_reg  <= step_res.offset;
            length_reg  <= step_res.length;
        end
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign payload_offset = offset_reg;
    assign payload_length = length_reg;

    // The input is held back only by a waiting verdict.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with an empty result register");

    // The byte that ends an archive returns the parser to the first signature byte.
    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && end_of_archive) |=> (state_reg.phase == PH_SIG0) && (pos_reg == '0))
        else $error("parse state not cleared after end of archive");

    // A verdict closes the archive: the parser waits for the end or has restarted.
    a_verdict_closes: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> (state_reg.phase == PH_DONE) || (state_reg.phase == PH_SIG0))
        else $error("parser still active after a verdict");

    // A found verdict always reports a payload of at least one byte.
    a_found_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        (load_result && step_res.verdict == V_FOUND) |=> (out_valid && length_reg != '0))
        else $error("found verdict with zero payload length");

endmodule
